// File: sv/tcsd_pkg.sv
package tcsd_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int IDX_W = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);
	localparam logic [IDX_W-1:0] IDX_THERMO_LO = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_THERMO_HI = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_JUNC_LO = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_JUNC_HI = IDX_W'(3);

	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [2:0] FLAG_OC = 3'h1;
	localparam logic [2:0] FLAG_SCG = 3'h2;
	localparam logic [2:0] FLAG_SCV = 3'h4;
	localparam logic [2:0] FLAG_MASK = FLAG_OC | FLAG_SCG | FLAG_SCV;

	localparam int TEMP_W = 19;
	localparam int CJ_W = 15;
	localparam int THERMO_W = 14;
	localparam int JUNC_W = 12;
	localparam int CJ_PROD_W = 17;

	localparam logic signed [TEMP_W-1:0] TC_SCALE = TEMP_W'(25);
	// 625 / 100 reduces to 25 / 4
	localparam logic signed [CJ_PROD_W-1:0] CJ_SCALE = CJ_PROD_W'(25);
	localparam logic signed [CJ_PROD_W-1:0] CJ_ROUND = CJ_PROD_W'(3);
	localparam int CJ_SHIFT = 2;

	typedef struct packed {
		logic                crc_ok;
		logic [THERMO_W-1:0] thermo;
		logic [JUNC_W-1:0]   junction;
		logic [2:0]          flags;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = b;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

// File: sv/tcsd_in_if.sv
interface tcsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

// File: sv/tcsd_out_if.sv
interface tcsd_out_if;
	logic                                valid;
	logic                                ready;
	logic                                status;
	logic signed [tcsd_pkg::TEMP_W-1:0] temperature_centi;
	logic signed [tcsd_pkg::CJ_W-1:0]   cold_junction_centi;
	logic [2:0]                          fault_flags;

	modport source(output valid, output status, output temperature_centi,
		output cold_junction_centi, output fault_flags, input ready);
	modport sink(input valid, input status, input temperature_centi,
		input cold_junction_centi, input fault_flags, output ready);
endinterface

// File: sv/tcsd_front.sv
module tcsd_front (
	input  logic              clk,
	input  logic              arst_n,
	tcsd_in_if.sink           scratch,
	output logic              frame_valid,
	output tcsd_pkg::frame_t  frame,
	input  logic              frame_ready
);

	logic [tcsd_pkg::IDX_W-1:0]    byte_index_q;
	logic [7:0]                    crc_q;
	logic [tcsd_pkg::THERMO_W-1:0] thermo_q;
	logic [tcsd_pkg::JUNC_W-1:0]   junction_q;
	logic                          first_lsb_q;
	logic [2:0]                    fault_q;
	logic                          last;
	logic                          accept;

	assign last = byte_index_q >= tcsd_pkg::IDX_LAST;
	assign scratch.ready = !last || frame_ready;
	assign accept = scratch.valid && scratch.ready;

	assign frame_valid = scratch.valid && last;
	always_comb begin
		frame.crc_ok = crc_q == scratch.data_byte;
		frame.thermo = thermo_q;
		frame.junction = junction_q;
		frame.flags = first_lsb_q ? (fault_q & tcsd_pkg::FLAG_MASK) : 3'b000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q <= '0;
		end else if (accept) begin
			if (last) begin
				byte_index_q <= '0;
				crc_q <= '0;
			end else begin
				byte_index_q <= byte_index_q + tcsd_pkg::IDX_W'(1);
				crc_q <= tcsd_pkg::crc8_byte(crc_q, scratch.data_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last) begin
			case (byte_index_q)
				tcsd_pkg::IDX_THERMO_LO: begin
					thermo_q[5:0] <= scratch.data_byte[7:2];
					first_lsb_q <= scratch.data_byte[0];
				end
				tcsd_pkg::IDX_THERMO_HI: begin
					thermo_q[13:6] <= scratch.data_byte;
				end
				tcsd_pkg::IDX_JUNC_LO: begin
					junction_q[3:0] <= scratch.data_byte[7:4];
					fault_q <= scratch.data_byte[2:0];
				end
				tcsd_pkg::IDX_JUNC_HI: begin
					junction_q[11:4] <= scratch.data_byte;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/tcsd_queue.sv
module tcsd_queue #(
	parameter int DEPTH = tcsd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  tcsd_pkg::frame_t push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output tcsd_pkg::frame_t pop_data,
	input  logic             pop_ready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

	tcsd_pkg::frame_t entries_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != COUNT_FULL;
	assign pop_valid = count_q != '0;
	assign pop_data = entries_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/tcsd_back.sv
module tcsd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	input  tcsd_pkg::frame_t frame,
	output logic             frame_ready,
	tcsd_out_if.source       result
);

	logic signed [tcsd_pkg::TEMP_W-1:0]    tc_c;
	logic signed [tcsd_pkg::CJ_PROD_W-1:0] cj_prod;
	logic signed [tcsd_pkg::CJ_PROD_W-1:0] cj_adj;
	logic signed [tcsd_pkg::CJ_W-1:0]      cj_c;
	logic                                  valid_q;
	logic                                  status_q;
	logic signed [tcsd_pkg::TEMP_W-1:0]    temp_q;
	logic signed [tcsd_pkg::CJ_W-1:0]      cj_q;
	logic [2:0]                            flags_q;
	logic                                  load;

	always_comb begin
		tc_c = tcsd_pkg::TEMP_W'($signed(frame.thermo)) * tcsd_pkg::TC_SCALE;
		cj_prod = tcsd_pkg::CJ_PROD_W'($signed(frame.junction)) * tcsd_pkg::CJ_SCALE;
		// truncate toward zero
		cj_adj = cj_prod[tcsd_pkg::CJ_PROD_W-1] ? cj_prod + tcsd_pkg::CJ_ROUND : cj_prod;
		cj_c = tcsd_pkg::CJ_W'(cj_adj >>> tcsd_pkg::CJ_SHIFT);
	end

	assign frame_ready = !valid_q || result.ready;
	assign load = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (frame_ready) begin
			valid_q <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= !frame.crc_ok;
			temp_q <= frame.crc_ok ? tc_c : '0;
			cj_q <= frame.crc_ok ? cj_c : '0;
			flags_q <= frame.crc_ok ? frame.flags : 3'b000;
		end
	end

	assign result.valid = valid_q;
	assign result.status = status_q;
	assign result.temperature_centi = temp_q;
	assign result.cold_junction_centi = cj_q;
	assign result.fault_flags = flags_q;

endmodule

// File: sv/thermocouple_scratchpad_decoder.sv
// Scratchpad decoder for a 1-Wire thermocouple converter.
// Channel scratch (sink): one scratchpad byte per transaction, nine bytes a
// frame, byte 0 first. Bytes 0 to 7 feed a reflected CRC-8 (poly 0x8C) and
// bytes 0 to 3 are kept; byte 8 is the received CRC.
// Channel result (source): one transaction per frame with status, the
// thermocouple and cold-junction temperatures in hundredths of a degree and
// the fault flags. On a CRC mismatch status is 1 and the other fields are 0.
// Throughput: one byte per cycle while the last byte is not held off; the
// CRC of a byte is computed in the cycle it is taken.
// Path: the frame taken with the ninth byte passes a two-entry queue and
// the scaling multiply ahead of the output register.
// Stall: while result is stalled, up to the queue depth plus one decoded
// frames wait; bytes 0 to 7 of the next frame are always taken, the last
// byte is held off (ready low) only while the queue is full.
// Reset: byte count and CRC clear, queue and output register empty.
module thermocouple_scratchpad_decoder #(
	parameter int QUEUE_DEPTH = tcsd_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	tcsd_in_if.sink    scratch,
	tcsd_out_if.source result
);

	logic             push_valid;
	logic             push_ready;
	tcsd_pkg::frame_t push_data;
	logic             pop_valid;
	logic             pop_ready;
	tcsd_pkg::frame_t pop_data;

	tcsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.scratch     (scratch),
		.frame_valid (push_valid),
		.frame       (push_data),
		.frame_ready (push_ready)
	);

	tcsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	tcsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (pop_valid),
		.frame       (pop_data),
		.frame_ready (pop_ready),
		.result      (result)
	);

endmodule

// File: sv/tcsd_checker.sv
module tcsd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                status,
	input logic signed [tcsd_pkg::TEMP_W-1:0] temperature_centi,
	input logic signed [tcsd_pkg::CJ_W-1:0]   cold_junction_centi,
	input logic [2:0]                          fault_flags
);

	logic [tcsd_pkg::IDX_W-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_valid && in_ready) begin
			seen_q <= (seen_q >= tcsd_pkg::IDX_LAST) ? '0 : seen_q + tcsd_pkg::IDX_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(temperature_centi) && $stable(cold_junction_centi)
			&& $stable(fault_flags))
	else $error("result dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> temperature_centi == '0 && cold_junction_centi == '0
			&& fault_flags == 3'b000)
	else $error("CRC mismatch with nonzero values");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> cold_junction_centi >= -15'sd12800
			&& cold_junction_centi <= 15'sd12793)
	else $error("cold junction out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < tcsd_pkg::IDX_LAST |-> in_ready)
	else $error("byte before the last of a frame was held off");

endmodule

bind thermocouple_scratchpad_decoder tcsd_checker u_tcsd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (scratch.valid),
	.in_ready            (scratch.ready),
	.out_valid           (result.valid),
	.out_ready           (result.ready),
	.status              (result.status),
	.temperature_centi   (result.temperature_centi),
	.cold_junction_centi (result.cold_junction_centi),
	.fault_flags         (result.fault_flags)
);
